/* hw/rtl/swrt_pkg.sv */
package swrt_pkg;

	// configuration register indexes (byte address = 4 * index)
	typedef enum logic [2:0] {
		REG_ROW_PAD           = 3'd0,
		REG_ROW_HYST          = 3'd1,
		REG_MIN_HEIGHT        = 3'd2,
		REG_SIDE_MARGIN       = 3'd3,
		REG_COL_HYST          = 3'd4,
		REG_MIN_WIDTH         = 3'd5,
		REG_GAIN_HOLD_FRAMES  = 3'd6,
		REG_RESET_HOLD_FRAMES = 3'd7
	} cfg_reg_t;

	localparam logic [9:0]  ROW_PAD_RST           = 10'd100;
	localparam logic [9:0]  ROW_HYST_RST          = 10'd40;
	localparam logic [11:0] MIN_HEIGHT_RST        = 12'd500;
	localparam logic [9:0]  SIDE_MARGIN_RST       = 10'd200;
	localparam logic [9:0]  COL_HYST_RST          = 10'd40;
	localparam logic [12:0] MIN_WIDTH_RST         = 13'd1200;
	localparam logic [7:0]  GAIN_HOLD_FRAMES_RST  = 8'd100;
	localparam logic [7:0]  RESET_HOLD_FRAMES_RST = 8'd25;

	localparam logic [12:0] SAT13_MAX = 13'h1FFF;
	localparam logic [7:0]  CNT_MAX   = 8'hFF;

endpackage

/* hw/rtl/scan_window_roi_tracker.sv */
// Path: each summary passes through the input register, then the result register.
// Throughput: one summary per cycle while out_ready keeps the result register free;
// request and counter state update at the edge the result register loads. A held result
// stalls the input only when the input register is full.
// Reset (arst_n low, asynchronous): both registers empty, no pending requests, frame counter 0,
// configuration registers at their documented defaults.
module scan_window_roi_tracker #(
	parameter int FULL_ROWS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// frame summary channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        parse_ok,
	input  logic        history_ready,
	input  logic [11:0] joint_top,
	input  logic [11:0] joint_bottom,
	input  logic [11:0] cur_row_offset,
	input  logic [12:0] cur_rows,
	input  logic        edges_ok,
	input  logic signed [13:0] left_edge_col,
	input  logic signed [13:0] right_edge_col,
	input  logic [12:0] cur_col_offset,
	input  logic [12:0] cur_cols,
	input  logic        gain_hint,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        set_rows,
	output logic [11:0] new_row_offset,
	output logic [12:0] new_rows,
	output logic        set_cols,
	output logic [12:0] new_col_offset,
	output logic [12:0] new_cols,
	output logic        gain_pulse,
	output logic        reset_pulse,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import swrt_pkg::*;

	localparam logic [12:0] FULL_ROWS_H = 13'(FULL_ROWS);

	// configuration
	logic [9:0]  row_pad_q, row_hyst_q, side_margin_q, col_hyst_q;
	logic [11:0] min_height_q;
	logic [12:0] min_width_q;
	logic [7:0]  gain_hold_frames_q, reset_hold_frames_q;
	logic        cfg_wr;
	cfg_reg_t    cfg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_sel = cfg_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pad_q           <= ROW_PAD_RST;
			row_hyst_q          <= ROW_HYST_RST;
			min_height_q        <= MIN_HEIGHT_RST;
			side_margin_q       <= SIDE_MARGIN_RST;
			col_hyst_q          <= COL_HYST_RST;
			min_width_q         <= MIN_WIDTH_RST;
			gain_hold_frames_q  <= GAIN_HOLD_FRAMES_RST;
			reset_hold_frames_q <= RESET_HOLD_FRAMES_RST;
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_ROW_PAD:           row_pad_q           <= pwdata[9:0];
				REG_ROW_HYST:          row_hyst_q          <= pwdata[9:0];
				REG_MIN_HEIGHT:        min_height_q        <= pwdata[11:0];
				REG_SIDE_MARGIN:       side_margin_q       <= pwdata[9:0];
				REG_COL_HYST:          col_hyst_q          <= pwdata[9:0];
				REG_MIN_WIDTH:         min_width_q         <= pwdata[12:0];
				REG_GAIN_HOLD_FRAMES:  gain_hold_frames_q  <= pwdata[7:0];
				REG_RESET_HOLD_FRAMES: reset_hold_frames_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_ROW_PAD:           prdata = 32'(row_pad_q);
			REG_ROW_HYST:          prdata = 32'(row_hyst_q);
			REG_MIN_HEIGHT:        prdata = 32'(min_height_q);
			REG_SIDE_MARGIN:       prdata = 32'(side_margin_q);
			REG_COL_HYST:          prdata = 32'(col_hyst_q);
			REG_MIN_WIDTH:         prdata = 32'(min_width_q);
			REG_GAIN_HOLD_FRAMES:  prdata = 32'(gain_hold_frames_q);
			REG_RESET_HOLD_FRAMES: prdata = 32'(reset_hold_frames_q);
			default:               prdata = '0;
		endcase
	end

	// input register
	logic        valid_s1;
	logic        parse_ok_s1, history_ready_s1, edges_ok_s1, gain_hint_s1;
	logic [11:0] top_s1, bottom_s1, row_off_s1;
	logic [12:0] rows_s1, col_off_s1, cols_s1;
	logic signed [13:0] lcol_s1, rcol_s1;
	logic        advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			parse_ok_s1      <= parse_ok;
			history_ready_s1 <= history_ready;
			top_s1           <= joint_top;
			bottom_s1        <= joint_bottom;
			row_off_s1       <= cur_row_offset;
			rows_s1          <= cur_rows;
			edges_ok_s1      <= edges_ok;
			lcol_s1          <= left_edge_col;
			rcol_s1          <= right_edge_col;
			col_off_s1       <= cur_col_offset;
			cols_s1          <= cur_cols;
			gain_hint_s1     <= gain_hint;
		end
	end

	// tracker state
	logic        row_pend_q, col_pend_q;
	logic [11:0] row_off_q;
	logic [12:0] row_h_q, col_off_q, col_w_q;
	logic [7:0]  cnt_q;

	// vertical window
	logic signed [14:0] top_x, bot_x, wm_x, mm_x, mh_x, off_x, h_x;
	logic signed [14:0] dtop, dbot, nh0;
	logic [14:0] short_by, adj;
	logic [11:0] noff0, noff1;
	logic [12:0] nh1;
	logic        row_free, covered, moved, row_change, row_fire;

	always_comb begin
		top_x = $signed(15'(top_s1));
		bot_x = $signed(15'(bottom_s1));
		wm_x  = $signed(15'(row_pad_q));
		mm_x  = $signed(15'(row_hyst_q));
		mh_x  = $signed(15'(min_height_q));
		off_x = $signed(15'(row_off_s1));
		h_x   = $signed(15'(rows_s1));

		row_free = !row_pend_q || (row_off_q == row_off_s1 && row_h_q == rows_s1);
		covered  = (h_x == mh_x) && (bot_x - top_x + (wm_x <<< 1) <= mh_x)
			&& (off_x + wm_x <= top_x) && (bot_x + wm_x <= off_x + h_x);
		dtop  = top_x - wm_x - off_x;
		dbot  = bot_x + wm_x - off_x - h_x;
		moved = (dtop > mm_x) || (dtop < -mm_x) || (dbot > mm_x) || (dbot < -mm_x);

		noff0 = (top_s1 > 12'(row_pad_q)) ? top_s1 - 12'(row_pad_q) : '0;
		nh0   = bot_x - $signed(15'(noff0)) + wm_x;
		// short window: grow to min_height, half of the growth above
		short_by = 15'(mh_x - nh0);
		adj      = short_by >> 1;
		if (nh0 < mh_x) begin
			noff1 = (15'(noff0) > adj) ? noff0 - adj[11:0] : '0;
			nh1   = 13'(min_height_q);
		end else begin
			noff1 = noff0;
			nh1   = nh0[12:0];
		end
		row_change = (noff1 != row_off_s1) || (nh1 != rows_s1);
		row_fire   = parse_ok_s1 && row_free && !covered && moved && row_change;
	end

	// horizontal window
	logic signed [15:0] l_x, r_x, lo, hi, sm_x, left0, left, right, w0, w1, minw_x, cw_x, co_x;
	logic signed [15:0] dw, doff, smm_x;
	logic [12:0] nw, ncoff;
	logic        col_free, col_moved, col_fire;

	always_comb begin
		l_x    = {{2{lcol_s1[13]}}, lcol_s1};
		r_x    = {{2{rcol_s1[13]}}, rcol_s1};
		lo     = (l_x < r_x) ? l_x : r_x;
		hi     = (l_x < r_x) ? r_x : l_x;
		sm_x   = $signed(16'(side_margin_q));
		smm_x  = $signed(16'(col_hyst_q));
		minw_x = $signed(16'(min_width_q));
		cw_x   = $signed(16'(cols_s1));
		co_x   = $signed(16'(col_off_s1));
		left0  = lo - sm_x;
		left   = (left0 < 0) ? '0 : left0;
		right  = hi + sm_x;
		w0     = right - left;
		w1     = (w0 < minw_x) ? minw_x : w0;
		nw     = (w1 > $signed(16'(SAT13_MAX))) ? SAT13_MAX : w1[12:0];
		ncoff  = left[12:0];
		col_free  = !col_pend_q || (col_off_q == col_off_s1 && col_w_q == cols_s1);
		dw        = cw_x - $signed(16'(nw));
		doff      = co_x - $signed(16'(ncoff));
		col_moved = (dw > smm_x) || (dw < -smm_x) || (doff > smm_x) || (doff < -smm_x);
		col_fire  = parse_ok_s1 && edges_ok_s1 && col_free && col_moved;
	end

	// frame counter, gain and reset pulses
	logic [7:0] cnt_inc;
	logic       gain_fire, reset_fire;

	assign cnt_inc    = (cnt_q == CNT_MAX) ? CNT_MAX : cnt_q + 8'd1;
	assign gain_fire  = parse_ok_s1 && gain_hint_s1 && (cnt_inc > gain_hold_frames_q);
	assign reset_fire = !parse_ok_s1 && !history_ready_s1 && !row_pend_q
		&& (row_off_s1 != '0) && (cnt_q > reset_hold_frames_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pend_q <= 1'b0;
			row_off_q  <= '0;
			row_h_q    <= '0;
			col_pend_q <= 1'b0;
			col_off_q  <= '0;
			col_w_q    <= '0;
			cnt_q      <= '0;
		end else if (advance) begin
			if (parse_ok_s1) begin
				if (row_free) begin
					if (!covered && moved) begin
						if (row_change) begin
							row_pend_q <= 1'b1;
							row_off_q  <= noff1;
							row_h_q    <= nh1;
						end
					end else begin
						row_pend_q <= 1'b0;
					end
				end
				if (edges_ok_s1 && col_free) begin
					col_pend_q <= col_moved;
					if (col_moved) begin
						col_off_q <= ncoff;
						col_w_q   <= nw;
					end
				end
				cnt_q <= gain_fire ? '0 : cnt_inc;
			end else if (reset_fire) begin
				row_pend_q <= 1'b1;
				row_off_q  <= '0;
				row_h_q    <= FULL_ROWS_H;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			set_rows       <= row_fire;
			new_row_offset <= row_fire ? noff1 : '0;
			new_rows       <= row_fire ? nh1 : '0;
			set_cols       <= col_fire;
			new_col_offset <= col_fire ? ncoff : '0;
			new_cols       <= col_fire ? nw : '0;
			gain_pulse     <= gain_fire;
			reset_pulse    <= reset_fire;
		end
	end

	// a reset request only comes from a failed frame, so it never shares a result with
	// a window request or a gain pulse
	a_reset_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reset_pulse |-> !set_rows && !set_cols && !gain_pulse)
		else $error("reset pulse together with another request");

	a_idle_rows_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !set_rows |-> new_rows == '0 && new_row_offset == '0)
		else $error("row fields nonzero without set_rows");

	a_reset_pends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && reset_fire |=> row_pend_q && row_off_q == '0 && row_h_q == FULL_ROWS_H)
		else $error("reset did not lock the default vertical window");

	a_gain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && gain_fire |=> cnt_q == '0)
		else $error("frame counter not cleared after gain pulse");

	a_set_rows_pends: assert property (@(posedge clk) disable iff (!arst_n)
		advance && row_fire |=> row_pend_q && row_off_q == new_row_offset && row_h_q == new_rows)
		else $error("vertical request not held pending");

endmodule

/* test/scan_window_roi_tracker_checker.sv */
`timescale 1ns / 1ps

module scan_window_roi_tracker_checker #(
	parameter int FULL_ROWS = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               parse_ok,
	input  logic               history_ready,
	input  logic [11:0]        joint_top,
	input  logic [11:0]        joint_bottom,
	input  logic [11:0]        cur_row_offset,
	input  logic [12:0]        cur_rows,
	input  logic               edges_ok,
	input  logic signed [13:0] left_edge_col,
	input  logic signed [13:0] right_edge_col,
	input  logic [12:0]        cur_col_offset,
	input  logic [12:0]        cur_cols,
	input  logic               gain_hint,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               set_rows,
	input  logic [11:0]        new_row_offset,
	input  logic [12:0]        new_rows,
	input  logic               set_cols,
	input  logic [12:0]        new_col_offset,
	input  logic [12:0]        new_cols,
	input  logic               gain_pulse,
	input  logic               reset_pulse,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 in_flight
);
	import swrt_pkg::*;

	typedef struct packed {
		logic               parse_ok;
		logic               history_ready;
		logic [11:0]        joint_top;
		logic [11:0]        joint_bottom;
		logic [11:0]        cur_row_offset;
		logic [12:0]        cur_rows;
		logic               edges_ok;
		logic signed [13:0] left_edge_col;
		logic signed [13:0] right_edge_col;
		logic [12:0]        cur_col_offset;
		logic [12:0]        cur_cols;
		logic               gain_hint;
	} frame_t;

	typedef struct packed {
		logic        set_rows;
		logic [11:0] new_row_offset;
		logic [12:0] new_rows;
		logic        set_cols;
		logic [12:0] new_col_offset;
		logic [12:0] new_cols;
		logic        gain_pulse;
		logic        reset_pulse;
	} window_cmd_t;

	window_cmd_t window_cmds[$];
	int          errs = 0;

	// shadow of the register file
	logic [9:0]  row_pad;
	logic [9:0]  row_hyst;
	logic [11:0] min_height;
	logic [9:0]  side_margin;
	logic [9:0]  col_hyst;
	logic [12:0] min_width;
	logic [7:0]  gain_hold;
	logic [7:0]  reset_hold;

	// request locks and frame counter
	logic        row_pend;
	logic [11:0] row_off;
	logic [12:0] row_h;
	logic        col_pend;
	logic [12:0] col_off;
	logic [12:0] col_w;
	logic [7:0]  frame_cnt;

	function automatic int iabs(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [12:0] sat13(int v);
		if (v < 0)
			return '0;
		if (v > int'(SAT13_MAX))
			return SAT13_MAX;
		return v[12:0];
	endfunction

	function automatic window_cmd_t track_frame(frame_t f);
		int          top, bot, roff, rows, wm, mm, mh, noff, nh, adj;
		int          lo, hi, left, right, w, coff, cols, smm;
		logic [12:0] nhs, nw, nco;
		logic        covered, moved;
		window_cmd_t r;
		r = '0;
		top = f.joint_top;
		bot = f.joint_bottom;
		roff = f.cur_row_offset;
		rows = f.cur_rows;
		coff = f.cur_col_offset;
		cols = f.cur_cols;
		wm = row_pad;
		mm = row_hyst;
		mh = min_height;
		smm = col_hyst;
		if (f.parse_ok) begin
			if (!row_pend || (row_off == f.cur_row_offset && row_h == f.cur_rows)) begin
				// a minimum-height window that already holds the joint stays put
				covered = rows == mh && bot - top + 2 * wm <= mh &&
					roff + wm <= top && bot + wm <= roff + rows;
				moved = iabs(top - wm - roff) > mm || iabs(bot + wm - roff - rows) > mm;
				if (!covered && moved) begin
					noff = top > wm ? top - wm : 0;
					nh = bot - noff + wm;
					if (nh < mh) begin
						adj = (mh - nh) / 2;
						noff = noff > adj ? noff - adj : 0;
						nh = mh;
					end
					nhs = sat13(nh);
					if (noff != roff || int'(nhs) != rows) begin
						row_pend = 1'b1;
						row_off = noff[11:0];
						row_h = nhs;
						r.set_rows = 1'b1;
						r.new_row_offset = noff[11:0];
						r.new_rows = nhs;
					end
				end else begin
					row_pend = 1'b0;
				end
			end
			if (f.edges_ok) begin
				lo = $signed(f.left_edge_col);
				hi = $signed(f.right_edge_col);
				if (lo > hi) begin
					w = lo;
					lo = hi;
					hi = w;
				end
				left = lo - int'(side_margin);
				right = hi + int'(side_margin);
				if (left < 0)
					left = 0;
				w = right - left;
				if (w < int'(min_width))
					w = int'(min_width);
				nw = sat13(w);
				nco = sat13(left);
				if (!col_pend || (col_off == f.cur_col_offset && col_w == f.cur_cols)) begin
					if (iabs(cols - int'(nw)) > smm || iabs(coff - int'(nco)) > smm) begin
						col_pend = 1'b1;
						col_off = nco;
						col_w = nw;
						r.set_cols = 1'b1;
						r.new_col_offset = nco;
						r.new_cols = nw;
					end else begin
						col_pend = 1'b0;
					end
				end
			end
			if (frame_cnt != CNT_MAX)
				frame_cnt = frame_cnt + 8'd1;
			if (frame_cnt > gain_hold && f.gain_hint) begin
				r.gain_pulse = 1'b1;
				frame_cnt = '0;
			end
		end else if (!f.history_ready) begin
			if (!row_pend && f.cur_row_offset != 0 && frame_cnt > reset_hold) begin
				r.reset_pulse = 1'b1;
				row_pend = 1'b1;
				row_off = '0;
				row_h = 13'(FULL_ROWS);
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_cmd_t exp_cmd;
		frame_t      f;
		if (!arst_n) begin
			row_pad = ROW_PAD_RST;
			row_hyst = ROW_HYST_RST;
			min_height = MIN_HEIGHT_RST;
			side_margin = SIDE_MARGIN_RST;
			col_hyst = COL_HYST_RST;
			min_width = MIN_WIDTH_RST;
			gain_hold = GAIN_HOLD_FRAMES_RST;
			reset_hold = RESET_HOLD_FRAMES_RST;
			row_pend = 1'b0;
			row_off = '0;
			row_h = '0;
			col_pend = 1'b0;
			col_off = '0;
			col_w = '0;
			frame_cnt = '0;
			window_cmds.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (cfg_reg_t'(paddr[4:2]))
					REG_ROW_PAD:           row_pad = pwdata[9:0];
					REG_ROW_HYST:          row_hyst = pwdata[9:0];
					REG_MIN_HEIGHT:        min_height = pwdata[11:0];
					REG_SIDE_MARGIN:       side_margin = pwdata[9:0];
					REG_COL_HYST:          col_hyst = pwdata[9:0];
					REG_MIN_WIDTH:         min_width = pwdata[12:0];
					REG_GAIN_HOLD_FRAMES:  gain_hold = pwdata[7:0];
					REG_RESET_HOLD_FRAMES: reset_hold = pwdata[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (window_cmds.size() == 0) begin
					$error("result transfer with no command expected");
					errs++;
				end else begin
					exp_cmd = window_cmds.pop_front();
					check_field("set_rows", exp_cmd.set_rows, set_rows);
					check_field("new_row_offset", exp_cmd.new_row_offset, new_row_offset);
					check_field("new_rows", exp_cmd.new_rows, new_rows);
					check_field("set_cols", exp_cmd.set_cols, set_cols);
					check_field("new_col_offset", exp_cmd.new_col_offset, new_col_offset);
					check_field("new_cols", exp_cmd.new_cols, new_cols);
					check_field("gain_pulse", exp_cmd.gain_pulse, gain_pulse);
					check_field("reset_pulse", exp_cmd.reset_pulse, reset_pulse);
				end
			end
			if (in_valid && in_ready) begin
				f = '{parse_ok, history_ready, joint_top, joint_bottom, cur_row_offset,
					cur_rows, edges_ok, left_edge_col, right_edge_col, cur_col_offset,
					cur_cols, gain_hint};
				window_cmds.insert(window_cmds.size(), track_frame(f));
			end
		end
		mismatches <= errs;
		in_flight <= window_cmds.size();
	end

endmodule

/* test/scan_window_roi_tracker_test.sv */
`timescale 1ns / 1ps

module scan_window_roi_tracker_test;
	import swrt_pkg::*;

	localparam int FULL_ROWS = 4096;
	localparam int MAX_GAP = 5;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               parse_ok = 1'b0;
	logic               history_ready = 1'b0;
	logic [11:0]        joint_top = '0;
	logic [11:0]        joint_bottom = '0;
	logic [11:0]        cur_row_offset = '0;
	logic [12:0]        cur_rows = '0;
	logic               edges_ok = 1'b0;
	logic signed [13:0] left_edge_col = '0;
	logic signed [13:0] right_edge_col = '0;
	logic [12:0]        cur_col_offset = '0;
	logic [12:0]        cur_cols = '0;
	logic               gain_hint = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               set_rows;
	logic [11:0]        new_row_offset;
	logic [12:0]        new_rows;
	logic               set_cols;
	logic [12:0]        new_col_offset;
	logic [12:0]        new_cols;
	logic               gain_pulse;
	logic               reset_pulse;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	int                 mismatches;
	int                 in_flight;

	// camera window as the sensor reports it, follows the block's requests
	int cam_roff = 0;
	int cam_rows = FULL_ROWS;
	int cam_coff = 0;
	int cam_cols = 8191;
	// where the joint sits in the scene
	int scene_row = 2000;
	int scene_col = 4000;
	bit idle_on = 1'b1;
	int rx_hold = 0;

	scan_window_roi_tracker #(.FULL_ROWS(FULL_ROWS)) uut (.*);

	scan_window_roi_tracker_checker #(.FULL_ROWS(FULL_ROWS)) cmd_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clamp(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int spread(int half);
		return int'($urandom_range(0, 2 * half)) - half;
	endfunction

	task automatic send_frame(
		input logic               po,
		input logic               hr,
		input logic [11:0]        jt,
		input logic [11:0]        jb,
		input logic [11:0]        ro,
		input logic [12:0]        rr,
		input logic               eo,
		input logic signed [13:0] lc,
		input logic signed [13:0] rc,
		input logic [12:0]        co,
		input logic [12:0]        cc,
		input logic               gh
	);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		parse_ok <= po;
		history_ready <= hr;
		joint_top <= jt;
		joint_bottom <= jb;
		cur_row_offset <= ro;
		cur_rows <= rr;
		edges_ok <= eo;
		left_edge_col <= lc;
		right_edge_col <= rc;
		cur_col_offset <= co;
		cur_cols <= cc;
		gain_hint <= gh;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic random_frame();
		int   jt, jb, lc, rc, tmp;
		logic cam;
		if ($urandom_range(0, 9) == 0) begin
			// noise: every field anywhere in its range
			send_frame(1'($urandom), 1'($urandom), 12'($urandom), 12'($urandom),
				12'($urandom), 13'($urandom), 1'($urandom), 14'($urandom),
				14'($urandom), 13'($urandom), 13'($urandom), 1'($urandom));
		end else begin
			if ($urandom_range(0, 49) == 0)
				scene_row = $urandom_range(0, 4095);
			else
				scene_row = clamp(scene_row + spread(30), 0, 4095);
			if ($urandom_range(0, 49) == 0)
				scene_col = int'($urandom_range(0, 8791)) - 600;
			else
				scene_col = clamp(scene_col + spread(40), -600, 8191);
			jt = scene_row;
			jb = clamp(jt + int'($urandom_range(0, 400)), 0, 4095);
			if ($urandom_range(0, 19) == 0) begin
				tmp = jt;
				jt = jb;
				jb = tmp;
			end
			lc = clamp(scene_col + spread(20), -8192, 8191);
			rc = clamp(lc + int'($urandom_range(0, 1500)), -8192, 8191);
			if ($urandom_range(0, 9) == 0) begin
				tmp = lc;
				lc = rc;
				rc = tmp;
			end
			cam = $urandom_range(0, 19) != 0;
			send_frame($urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), 12'(jt), 12'(jb),
				12'(cam ? cam_roff : int'($urandom)), 13'(cam ? cam_rows : int'($urandom)),
				$urandom_range(0, 9) != 0, 14'(lc), 14'(rc),
				13'(cam ? cam_coff : int'($urandom)), 13'(cam ? cam_cols : int'($urandom)),
				1'($urandom_range(0, 1)));
		end
	endtask

	task automatic run_frames(input int n);
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0)
				idle_on = $urandom_range(0, 3) != 0;
			random_frame();
		end
	endtask

	// stop offering and wait for every command to come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (in_flight != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input int wm, input int mm, input int mh, input int sm,
		input int smm, input int mw, input int ghf, input int rhf);
		drain();
		write_reg(REG_ROW_PAD, wm);
		write_reg(REG_ROW_HYST, mm);
		write_reg(REG_MIN_HEIGHT, mh);
		write_reg(REG_SIDE_MARGIN, sm);
		write_reg(REG_COL_HYST, smm);
		write_reg(REG_MIN_WIDTH, mw);
		write_reg(REG_GAIN_HOLD_FRAMES, ghf);
		write_reg(REG_RESET_HOLD_FRAMES, rhf);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int stall, n;
		wait (arst_n);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
				repeat (n) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
			stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (set_rows) begin
				cam_roff = new_row_offset;
				cam_rows = new_rows;
			end
			if (set_cols) begin
				cam_coff = new_col_offset;
				cam_cols = new_cols;
			end
			if (reset_pulse) begin
				cam_roff = 0;
				cam_rows = FULL_ROWS;
			end
		end
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(ROW_PAD_RST, ROW_HYST_RST, MIN_HEIGHT_RST, SIDE_MARGIN_RST,
			COL_HYST_RST, MIN_WIDTH_RST, GAIN_HOLD_FRAMES_RST,
			RESET_HOLD_FRAMES_RST);
		// failed frame, counter too low for a reset
		send_frame(0, 0, 0, 0, 100, 0, 0, 0, 0, 0, 0, 0);
		send_frame(1, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		// camera meets both requests; joint already covered by min-height window
		send_frame(1, 1, 200, 300, 0, 500, 1, 200, 1000, 0, 1200, 0);
		// computed window equals the current one
		send_frame(1, 0, 50, 700, 0, 800, 0, 0, 0, 0, 1200, 1);
		// bottom above top, offset clamps at 0
		send_frame(1, 1, 300, 0, 0, 800, 0, 0, 0, 0, 1200, 0);
		send_frame(1, 1, 4095, 4095, 4095, 8191, 1, 8191, 8191, 8191, 8191, 1);
		// width saturates, far-negative left edge
		send_frame(1, 0, 0, 4095, 0, 500, 1, -8192, 8191, 7991, 1200, 0);
		send_frame(1, 1, 1000, 1200, 0, 4195, 1, -500, 300, 0, 8191, 1);
		send_frame(0, 1, 4095, 4095, 4095, 8191, 1, -1, -1, 8191, 8191, 1);
		send_frame(0, 0, 0, 0, 850, 500, 0, 0, 0, 0, 0, 1);
		// edges given right to left
		send_frame(1, 0, 900, 1000, 850, 500, 1, 3000, 1000, 0, 1200, 1);
		send_frame(1, 1, 900, 1000, 850, 500, 1, 3000, 1000, 0, 8191, 1);
		run_frames(230);

		configure(0, 0, 1, 0, 0, 1, 0, 0);
		send_frame(1, 1, 2000, 2100, 0, 500, 1, 100, 200, 0, 1, 1);
		send_frame(0, 0, 2000, 2100, 1, 500, 0, 100, 200, 0, 1, 0);
		run_frames(100);
		// long hold-off on the result side while frames keep coming
		rx_hold = 300;
		run_frames(120);

		configure(1023, 1023, 4095, 1023, 1023, 8191, 254, 254);
		run_frames(220);

		// zero minimums are legal too
		configure(0, 0, 0, 0, 0, 0, 0, 0);
		run_frames(220);

		repeat (3) begin
			configure($urandom_range(0, 300), $urandom_range(0, 100), $urandom_range(1, 1500),
				$urandom_range(0, 400), $urandom_range(0, 100), $urandom_range(1, 3000),
				$urandom_range(0, 254), $urandom_range(0, 60));
			run_frames(220);
		end

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && in_flight == 0) begin
			$display("** scan_window_roi_tracker: PASSED **");
		end else begin
			$display("** scan_window_roi_tracker: FAILED **");
		end
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("** scan_window_roi_tracker: FAILED **");
		$finish;
	end

endmodule
